FILE: design/lcd_pkg.sv
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types and constants of the luminance contrast debouncer.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int LUM_W   = 8;
  localparam int LEVEL_W = 5;
  localparam int RUN_W   = 9;
  localparam int ADDR_W  = 3;
  localparam int DIV_W   = 8;
  localparam int DIV_CNT_W = 3;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_W - 1);

  // Contrast levels
  localparam logic signed [LEVEL_W-1:0] LEVEL_TOP   = 5'sd15;
  localparam logic signed [LEVEL_W-1:0] LEVEL_FLOOR = 5'sd4;
  localparam logic signed [LEVEL_W-1:0] LEVEL_DARK  = 5'sd0;
  localparam logic signed [LEVEL_W-1:0] LEVEL_NONE  = -5'sd1;

  localparam logic [RUN_W-1:0] RUN_MAX = 9'd511;

  // Register reset values
  localparam logic [LUM_W-1:0] RST_MAX_LUM     = 8'd180;
  localparam logic [LUM_W-1:0] RST_MIN_LUM     = 8'd40;
  localparam logic [LUM_W-1:0] RST_LEVEL_COUNT = 8'd15;
  localparam logic [LUM_W-1:0] RST_HOLD_COUNT  = 8'd10;
  localparam logic [LUM_W-1:0] RST_DARK_THR    = 8'd10;

  // Register indexes
  localparam logic [ADDR_W-1:0] REG_MAX_LUM     = 3'd0;
  localparam logic [ADDR_W-1:0] REG_MIN_LUM     = 3'd1;
  localparam logic [ADDR_W-1:0] REG_LEVEL_COUNT = 3'd2;
  localparam logic [ADDR_W-1:0] REG_HOLD_COUNT  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_DARK_THR    = 3'd4;

  // Request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_EVENT  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_DIV_STEP,
    ST_DIV_LEVEL,
    ST_DEBOUNCE,
    ST_EMIT
  } lcd_state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: design/luminance_contrast_debouncer_top.sv
// ----------------------------------------------------------------------------
// luminance_contrast_debouncer_top
// Quantizes a frame's mean luminance to a contrast level and debounces it.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one transaction per request. s_tuser is the request
//   kind (0 luminance sample, 1 screen status event); s_tdata carries the
//   mean luminance and the screen-up flag. Master channel m_*: one
//   transaction per published contrast level, -1 meaning none published.
//   Configuration is written through cfg_we / cfg_addr / cfg_wdata while idle.
// Timing:
//   One request at a time; s_tready is high only when idle. A screen-up
//   event goes straight to the emit state, a screen-down event back to idle.
//   A special-case sample skips both divisions and a zero-step sample the
//   second. Each division runs 8 iterations of the shared divider.
// Reset:
//   rst (synchronous) restores the register defaults and clears the debounce
//   state: no candidate level, zero run, nothing published.
// Stall:
//   A result waits in the output register; while the previous result is not
//   taken the next one holds in the emit state and s_tready stays low.
// ----------------------------------------------------------------------------
module luminance_contrast_debouncer_top
  import lcd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [7:0] mean_luminance, [8] screen_up
  input  logic              s_tuser,   // [0] req_type
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [4:0] contrast
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_addr,
  input  logic [LUM_W-1:0]  cfg_wdata
);

  lcd_state_t state, state_next;

  logic [LUM_W-1:0] max_lum, min_lum, level_count, hold_count, dark_thr;

  logic                      req_kind;
  logic [LUM_W-1:0]          lum;
  logic                      screen_up;
  logic signed [LEVEL_W-1:0] level;
  logic signed [LEVEL_W-1:0] emit_value;
  logic signed [LEVEL_W-1:0] candidate_level;
  logic [RUN_W-1:0]          repeat_run;
  logic signed [LEVEL_W-1:0] published_level;
  logic signed [LEVEL_W-1:0] contrast;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                      class_hit;
  logic signed [LEVEL_W-1:0] class_level;
  logic signed [LEVEL_W-1:0] clamp_level;
  logic                      same_level;
  logic [RUN_W-1:0]          run_inc;
  logic                      publish;
  logic                      out_free;

  lcd_serial_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {3'b000, contrast};

  // Special-case classification, in the order of precedence
  always_comb begin
    class_hit   = 1'b1;
    class_level = LEVEL_TOP;
    if (lum >= max_lum) begin
      class_level = LEVEL_TOP;
    end else if (lum <= dark_thr) begin
      class_level = LEVEL_DARK;
    end else if (lum <= min_lum) begin
      class_level = LEVEL_FLOOR;
    end else if (level_count == '0) begin
      class_level = LEVEL_TOP;
    end else begin
      class_hit = 1'b0;
    end
  end

  always_comb begin
    if (div_rsp.quotient < DIV_W'(LEVEL_FLOOR)) begin
      clamp_level = LEVEL_FLOOR;
    end else if (div_rsp.quotient > DIV_W'(LEVEL_TOP)) begin
      clamp_level = LEVEL_TOP;
    end else begin
      clamp_level = LEVEL_W'(div_rsp.quotient);
    end
  end

  always_comb begin
    same_level = (level == candidate_level);
    run_inc    = (repeat_run < RUN_MAX) ? repeat_run + 1'b1 : repeat_run;
    publish    = (same_level && (run_inc == {1'b0, hold_count})
                  && (level != published_level))
                 || (published_level == LEVEL_NONE);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == REQ_EVENT) begin
            state_next = s_tdata[8] ? ST_EMIT : ST_IDLE;
          end else begin
            state_next = ST_CLASSIFY;
          end
        end
      end
      ST_CLASSIFY:  state_next = class_hit ? ST_DEBOUNCE : ST_DIV_STEP;
      ST_DIV_STEP: begin
        if (div_rsp.done) begin
          state_next = (div_rsp.quotient == '0) ? ST_DEBOUNCE : ST_DIV_LEVEL;
        end
      end
      ST_DIV_LEVEL: if (div_rsp.done) state_next = ST_DEBOUNCE;
      ST_DEBOUNCE:  state_next = publish ? ST_EMIT : ST_IDLE;
      ST_EMIT:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(max_lum - min_lum);
    div_req.divisor  = level_count;
    unique case (state)
      ST_CLASSIFY: div_req.start = !class_hit;
      ST_DIV_STEP: begin
        div_req.start    = div_rsp.done && (div_rsp.quotient != '0);
        div_req.dividend = DIV_W'(lum - min_lum);
        div_req.divisor  = div_rsp.quotient;
      end
      default: div_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      max_lum         <= RST_MAX_LUM;
      min_lum         <= RST_MIN_LUM;
      level_count     <= RST_LEVEL_COUNT;
      hold_count      <= RST_HOLD_COUNT;
      dark_thr        <= RST_DARK_THR;
      candidate_level <= LEVEL_NONE;
      repeat_run      <= '0;
      published_level <= LEVEL_NONE;
      m_tvalid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MAX_LUM:     max_lum     <= cfg_wdata;
          REG_MIN_LUM:     min_lum     <= cfg_wdata;
          REG_LEVEL_COUNT: level_count <= cfg_wdata;
          REG_HOLD_COUNT:  hold_count  <= cfg_wdata;
          REG_DARK_THR:    dark_thr    <= cfg_wdata;
          default: ;
        endcase
      end
      if (state == ST_DEBOUNCE) begin
        if (same_level) begin
          repeat_run <= run_inc;
        end else begin
          repeat_run      <= '0;
          candidate_level <= level;
        end
        if (publish) published_level <= level;
      end
      if (state == ST_EMIT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      req_kind   <= s_tuser;
      lum        <= s_tdata[7:0];
      screen_up  <= s_tdata[8];
      emit_value <= published_level;
    end
    if (state == ST_CLASSIFY && class_hit) level <= class_level;
    if (state == ST_DIV_STEP && div_rsp.done && div_rsp.quotient == '0) level <= LEVEL_TOP;
    if (state == ST_DIV_LEVEL && div_rsp.done) level <= clamp_level;
    if (state == ST_DEBOUNCE) emit_value <= level;
    if (state == ST_EMIT && out_free) contrast <= emit_value;
  end

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ($past(state) == ST_DEBOUNCE || $past(state) == ST_EMIT
      || ($past(state) == ST_IDLE && req_kind == REQ_EVENT && screen_up)))
    else $error("emit entered from wrong state");
  a_published_after_sample: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEBOUNCE) |=> (published_level != LEVEL_NONE))
    else $error("first sample did not publish");
  a_run_has_candidate: assert property (@(posedge clk) disable iff (rst)
    (repeat_run != '0) |-> (candidate_level != LEVEL_NONE))
    else $error("run counted without candidate");
  a_div_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !div_rsp.busy) else $error("divider busy while idle");
  a_negative_is_none: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[4]) |-> (m_tdata[4:0] == 5'h1f))
    else $error("invalid negative contrast");

endmodule

FILE: design/lcd_serial_div.sv
// ----------------------------------------------------------------------------
// lcd_serial_div
// Restoring divider, one quotient bit per cycle, shared by the step and level
// divisions. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module lcd_serial_div
  import lcd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] count;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     divisor;
  logic [DIV_W:0]       rem_shift;
  logic [DIV_W-1:0]     rem_next;
  logic [DIV_W-1:0]     quo_next;

  always_comb begin
    rem_shift = {rem, quo[DIV_W-1]};
    if (rem_shift >= {1'b0, divisor}) begin
      rem_next = DIV_W'(rem_shift - {1'b0, divisor});
      quo_next = {quo[DIV_W-2:0], 1'b1};
    end else begin
      rem_next = rem_shift[DIV_W-1:0];
      quo_next = {quo[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      // Pulse done after the last quotient bit
      done <= !req.start && busy && (count == DIV_LAST);
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == DIV_LAST) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= '0;
      quo     <= req.dividend;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy) else $error("done without a run");
  a_busy_length: assert property (@(posedge clk) disable iff (rst)
    req.start |=> ##(DIV_W) done) else $error("divider run length wrong");

endmodule
